[src/tksd_pkg.sv]
// ----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Shared types, byte constants and key codes for the decoder and its top level.
// ----------------------------------------------------------------------------
package tksd_pkg;

    localparam int SEQ_BYTES = 7;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;

    localparam logic [7:0] ESC_BYTE   = 8'h1b;
    localparam logic [7:0] CSI_BYTE   = 8'h5b;
    localparam logic [7:0] TILDE_BYTE = 8'h7e;
    localparam logic [7:0] SEMI_BYTE  = 8'h3b;
    localparam logic [7:0] CTRL_BIAS  = 8'h60;
    localparam logic [7:0] TAB_BYTE   = 8'h09;
    localparam logic [7:0] ENTER_BYTE = 8'h0d;
    localparam logic [7:0] DEL_BYTE   = 8'h7f;

    localparam logic [6:0] EXT_UP     = 7'd1;
    localparam logic [6:0] EXT_INSERT = 7'd5;
    localparam logic [6:0] EXT_DELETE = 7'd6;
    localparam logic [6:0] EXT_PGUP   = 7'd7;
    localparam logic [6:0] EXT_PGDOWN = 7'd8;
    localparam logic [6:0] EXT_END    = 7'd9;
    localparam logic [6:0] EXT_HOME   = 7'd10;

    typedef struct packed {
        logic [SEQ_BYTES-1:0][7:0] seq_b;
        logic [2:0]                valid_count;
    } key_group_t;

    typedef struct packed {
        logic       extended_key;
        logic       function_key;
        logic       mod_shift;
        logic       mod_alt;
        logic       mod_ctrl;
        logic       is_printable;
        logic [6:0] key_code;
    } key_result_t;

endpackage

[src/tksd_decode.sv]
// ----------------------------------------------------------------------------
// Terminal key sequence decoder: byte group decode
// Combinational decode of one masked byte group into a key code and flags.
// ----------------------------------------------------------------------------
module tksd_decode (
    input  tksd_pkg::key_group_t  group_in,
    output tksd_pkg::key_result_t result_out
);
    import tksd_pkg::*;

    logic [SEQ_BYTES-1:0][7:0] b;

    always_comb begin
        for (int i = 0; i < SEQ_BYTES; i++) begin
            b[i] = (3'(i) < group_in.valid_count) ? group_in.seq_b[i] : 8'h00;
        end
    end

    always_comb begin
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic [7:0] c4;
        logic [7:0] c5;
        logic [7:0] c6;
        c0 = b[0];
        c1 = b[1];
        c2 = b[2];
        c3 = b[3];
        c4 = b[4];
        c5 = b[5];
        c6 = b[6];
        result_out = '0;
        if (c0 != ESC_BYTE) begin
            if (c0 >= 8'h01 && c0 <= 8'h1a) begin
                result_out.key_code = c0[6:0];
                if (c0 == TAB_BYTE) begin
                    result_out.is_printable = 1'b1;
                end else if (c0 != ENTER_BYTE) begin
                    result_out.mod_ctrl = 1'b1;
                    result_out.key_code = 7'(c0 + CTRL_BIAS);
                end
            end else if (c0 >= 8'h20 && c0 <= DEL_BYTE) begin
                result_out.key_code     = c0[6:0];
                result_out.is_printable = (c0 != DEL_BYTE);
            end
        end else if (c1 == 8'h00) begin
            result_out.key_code = ESC_BYTE[6:0];
        end else if (c1 >= 8'h27 && c1 <= 8'h5a) begin
            if ((c1 <= 8'h2b) || (c1 >= 8'h41 && c1 <= 8'h4f && c2 == 8'h00) ||
                (c1 >= 8'h50)) begin
                result_out.key_code  = c1[6:0];
                result_out.mod_alt   = 1'b1;
                result_out.mod_shift = 1'b1;
            end else if (c1 == 8'h4f && c2 >= 8'h50 && c2 <= 8'h53) begin
                result_out.function_key = 1'b1;
                result_out.key_code     = 7'(c2 - 8'h4f);
            end
        end else if (c1 == CSI_BYTE) begin
            if (c2 == 8'h31) begin
                if (c3 >= 8'h35 && c3 <= 8'h39) begin
                    result_out.function_key = 1'b1;
                    result_out.key_code = (c3 == 8'h35) ? 7'd5 : 7'(c3 - 8'h31);
                    if (c4 != TILDE_BYTE) begin
                        if (c4 == SEMI_BYTE && c5 == 8'h32 && c6 == TILDE_BYTE) begin
                            result_out.mod_shift = 1'b1;
                        end else begin
                            result_out.key_code = 7'd0;
                        end
                    end
                end else if (c3 == SEMI_BYTE && c4 == 8'h32) begin
                    result_out.mod_shift = 1'b1;
                    if (c5 >= 8'h41 && c5 <= 8'h44) begin
                        result_out.extended_key = 1'b1;
                        result_out.key_code     = 7'(c5 - 8'h40);
                    end else if (c5 >= 8'h50 && c5 <= 8'h53) begin
                        result_out.function_key = 1'b1;
                        result_out.key_code     = 7'(c5 - 8'h4f);
                    end
                end
            end else if (c2 == 8'h32) begin
                if (c3 == 8'h30 || c3 == 8'h31 || c3 == 8'h34) begin
                    result_out.function_key = 1'b1;
                    result_out.key_code = (c3 == 8'h34) ? 7'd12 : 7'(c3 - 8'h27);
                    if (c4 == SEMI_BYTE && c5 == 8'h32 && c6 == TILDE_BYTE) begin
                        result_out.mod_shift = 1'b1;
                    end else if (c4 != TILDE_BYTE) begin
                        result_out.key_code = 7'd0;
                    end
                end else if (c3 == TILDE_BYTE) begin
                    result_out.extended_key = 1'b1;
                    result_out.key_code     = EXT_INSERT;
                end
            end else if (c2 == 8'h33) begin
                result_out.extended_key = 1'b1;
                if (c3 == SEMI_BYTE && c4 == 8'h32 && c5 == TILDE_BYTE) begin
                    result_out.mod_shift = 1'b1;
                    result_out.key_code  = EXT_DELETE;
                end else if (c3 == TILDE_BYTE) begin
                    result_out.key_code = EXT_DELETE;
                end
            end else if ((c2 == 8'h35 || c2 == 8'h36) && c3 == TILDE_BYTE) begin
                result_out.extended_key = 1'b1;
                result_out.key_code     = (c2 == 8'h35) ? EXT_PGUP : EXT_PGDOWN;
            end else if (c2 >= 8'h41 && c2 <= 8'h48) begin
                result_out.extended_key = 1'b1;
                if (c2 <= 8'h44) begin
                    result_out.key_code = 7'(c2 - 8'h41) + EXT_UP;
                end else if (c2 == 8'h46) begin
                    result_out.key_code = EXT_END;
                end else if (c2 == 8'h48) begin
                    result_out.key_code = EXT_HOME;
                end
            end
        end else if (c1 >= 8'h5c && c1 <= 8'h7c) begin
            result_out.mod_alt  = 1'b1;
            result_out.key_code = c1[6:0];
        end
    end

endmodule

[src/terminal_key_sequence_decoder.sv]
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Decodes one terminal read of up to seven bytes into a key code and flags.
//
//   Channel   Direction  Payload (from bit 0 up)
//   s_        in         valid_count[2:0], seq_b0 .. seq_b6, zero fill to 64
//   m_        out        key_code[6:0], is_printable, mod_ctrl, mod_alt,
//                        mod_shift, function_key, extended_key, zero fill to 16
//
// A request is registered at the input, decoded combinationally, and its result
// is registered at the output: m_tvalid rises once it moves to the output register.
// One request is taken every cycle while the result side keeps up.
// A stall on m_tready holds the result; the input stage still fills once.
// Reset clears both valid flags.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // valid_count, seq_b0, seq_b1, seq_b2, seq_b3, seq_b4, seq_b5, seq_b6
    input  logic [tksd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // key_code, is_printable, mod_ctrl, mod_alt, mod_shift, function_key,
    // extended_key
    output logic [tksd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tksd_pkg::*;

    localparam int GROUP_W  = $bits(key_group_t);
    localparam int RESULT_W = $bits(key_result_t);

    logic        in_valid_reg;
    key_group_t  in_group_reg;
    logic        out_valid_reg;
    key_result_t out_result_reg;
    key_result_t decoded;
    logic        out_load;
    logic        in_load;

    assign out_load = !out_valid_reg || m_tready;
    assign in_load  = !in_valid_reg || out_load;
    assign s_tready = in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_tvalid) begin
            in_group_reg <= key_group_t'(s_tdata[GROUP_W-1:0]);
        end
    end

    tksd_decode u_decode (
        .group_in   (in_group_reg),
        .result_out (decoded)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_result_reg <= decoded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_result_reg};

    a_fn_ex_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_result_reg.function_key && out_result_reg.extended_key))
        else $error("function and extended flags both set");

    a_printable_no_mod : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.is_printable) |->
        !(out_result_reg.mod_ctrl || out_result_reg.mod_alt || out_result_reg.mod_shift))
        else $error("printable key carries a modifier");

    a_ctrl_letter : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.mod_ctrl) |->
        (out_result_reg.key_code >= 7'h61 && out_result_reg.key_code <= 7'h7a))
        else $error("control key code out of letter range");

    a_advance : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load) |=> out_valid_reg)
        else $error("decoded request lost between stages");

endmodule
